// ----- sv/mau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared constants, stream layout, command codes and sequencer state types.
// ----------------------------------------------------------------------------
package mau_pkg;

    // Default modulus, the prime 1e9 + 7.
    localparam int unsigned DEFAULT_MODULUS = 32'd1000000007;

    // Field widths of one input item and one result item.
    localparam int CMD_W  = 3;
    localparam int OPND_W = 30;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;

    // Input tdata layout, lowest field first.
    localparam int IN_CMD_LSB = 0;
    localparam int IN_A_LSB   = IN_CMD_LSB + CMD_W;
    localparam int IN_B_LSB   = IN_A_LSB + OPND_W;
    localparam int IN_EXP_LSB = IN_B_LSB + OPND_W;
    localparam int IN_USED_W  = IN_EXP_LSB + EXP_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int OUT_RES_LSB = 0;
    localparam int OUT_EQ_BIT  = OUT_RES_LSB + RES_W;
    localparam int OUT_USED_W  = OUT_EQ_BIT + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_POW = 3'd4,
        CMD_INV = 3'd5
    } t_cmd;

    // Top level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POW_CHECK,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_MUL_WAIT,
        ST_OUT
    } t_state;

    // Modular multiplier sequencer.
    typedef enum logic [2:0] {
        MM_IDLE,
        MM_QUOT,
        MM_QMUL,
        MM_SUB,
        MM_FIX1,
        MM_FIX2
    } t_mm_state;

endpackage

// ----- sv/mau_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular multiplier
// Barrett reduction of x * y over one shared multiplier.
// ----------------------------------------------------------------------------
module mau_mulmod #(
    parameter int unsigned MODULUS = mau_pkg::DEFAULT_MODULUS,
    localparam int RW = $clog2(64'(MODULUS) + 64'd1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_x,
    input  logic [RW-1:0] i_y,
    output logic          o_done,
    output logic [RW-1:0] o_z
);

    localparam int MW = RW + 2;
    localparam logic [63:0] MU_FULL = (64'd1 << (2 * RW)) / 64'(MODULUS);
    localparam logic [MW-1:0] MU    = MW'(MU_FULL);
    localparam logic [MW-1:0] MOD_E = MW'(MODULUS);

    mau_pkg::t_mm_state r_state, n_state;
    logic [2*MW-1:0]    r_mp, n_mp;
    logic [MW-1:0]      r_plo, n_plo;
    logic [MW-1:0]      r_r, n_r;

    logic [MW-1:0]      w_ma, w_mb, w_fix;
    logic [2*MW-1:0]    w_mp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mau_pkg::MM_IDLE: begin
                if (i_start) begin
                    n_state = mau_pkg::MM_QUOT;
                end
            end
            mau_pkg::MM_QUOT: n_state = mau_pkg::MM_QMUL;
            mau_pkg::MM_QMUL: n_state = mau_pkg::MM_SUB;
            mau_pkg::MM_SUB:  n_state = mau_pkg::MM_FIX1;
            mau_pkg::MM_FIX1: n_state = mau_pkg::MM_FIX2;
            // A new product may start in the cycle that the previous one completes.
            mau_pkg::MM_FIX2: n_state = i_start ? mau_pkg::MM_QUOT : mau_pkg::MM_IDLE;
            default:          n_state = mau_pkg::MM_IDLE;
        endcase
    end

    // Operand selection of the shared multiplier and result correction.
    always_comb begin
        unique case (r_state)
            mau_pkg::MM_QUOT: begin
                w_ma = MW'(r_mp[2*RW-1:RW-1]);
                w_mb = MU;
            end
            mau_pkg::MM_QMUL: begin
                w_ma = r_mp[2*RW+2:RW+1];
                w_mb = MOD_E;
            end
            default: begin
                w_ma = MW'(i_x);
                w_mb = MW'(i_y);
            end
        endcase
        w_fix  = (r_r >= MOD_E) ? (r_r - MOD_E) : r_r;
        o_done = (r_state == mau_pkg::MM_FIX2);
        o_z    = RW'(w_fix);
    end

    assign w_mp = (2 * MW)'(w_ma) * (2 * MW)'(w_mb);

    always_comb begin
        n_mp  = r_mp;
        n_plo = r_plo;
        n_r   = r_r;
        unique case (r_state)
            mau_pkg::MM_IDLE: begin
                if (i_start) begin
                    n_mp = w_mp;
                end
            end
            mau_pkg::MM_QUOT: begin
                n_plo = r_mp[MW-1:0];
                n_mp  = w_mp;
            end
            mau_pkg::MM_QMUL: begin
                n_mp = w_mp;
            end
            // The estimate is short by at most two moduli, so the low bits suffice.
            mau_pkg::MM_SUB: begin
                n_r = r_plo - r_mp[MW-1:0];
            end
            mau_pkg::MM_FIX1: begin
                n_r = w_fix;
            end
            mau_pkg::MM_FIX2: begin
                if (i_start) begin
                    n_mp = w_mp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau_pkg::MM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mp  <= n_mp;
        r_plo <= n_plo;
        r_r   <= n_r;
    end

endmodule

// ----- sv/modular_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide, power and inverse modulo a fixed prime.
// ----------------------------------------------------------------------------
// One item enters on the slave stream and one result leaves on the master
// stream. The unit works on one item at a time: it is ready only when idle,
// and a result is held on the master side until it is taken, so a stalled
// receiver simply holds the unit. Operands at or above the modulus are
// saturated to the modulus minus one on entry.
// Add and subtract are computed in the execute state and go straight to the
// output state; multiply waits in between for the modular multiplier.
// Power walks the exponent bits up to the highest set bit through one shared
// modular multiplier: a set bit multiplies the accumulator by the square,
// and every bit squares the square.
// Inverse is the power to the modulus minus two; divide adds one multiply
// on top of that.
// After a result is taken the unit is ready again in the next cycle.
// Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
    parameter int unsigned MODULUS = mau_pkg::DEFAULT_MODULUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // command [2:0], operand_a [32:3], operand_b [62:33], exponent [125:63]
    input  logic [mau_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // result [29:0], operands_equal [30]
    output logic [mau_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int RW = $clog2(64'(MODULUS) + 64'd1);
    localparam logic [RW-1:0] MOD_MAX = RW'(MODULUS - 32'd1);
    localparam logic [RW:0]   MOD_W   = (RW + 1)'(MODULUS);
    localparam logic [RW-1:0] ONE     = RW'(1);
    localparam logic [mau_pkg::EXP_W-1:0] EXP_INV =
        mau_pkg::EXP_W'(MODULUS - 32'd2);

    mau_pkg::t_state             r_state, n_state;
    mau_pkg::t_cmd               r_cmd, n_cmd;
    logic [RW-1:0]               r_a, n_a;
    logic [RW-1:0]               r_b, n_b;
    logic                        r_eq, n_eq;
    logic [mau_pkg::EXP_W-1:0]   r_exp, n_exp;
    logic [RW-1:0]               r_acc, n_acc;
    logic [RW-1:0]               r_sq, n_sq;
    logic [RW-1:0]               r_res, n_res;

    logic                        w_accept;
    logic [31:0]                 w_a32, w_b32, w_res32;
    logic [RW-1:0]               w_a_sat, w_b_sat;
    logic [RW:0]                 w_sum, w_add, w_diff;
    logic                        w_exp_zero;

    logic                        mm_start, mm_done;
    logic [RW-1:0]               mm_x, mm_y, mm_z;

    mau_mulmod #(
        .MODULUS (MODULUS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .o_done  (mm_done),
        .o_z     (mm_z)
    );

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign w_a32   = 32'(i_s_axis_tdata[mau_pkg::IN_A_LSB +: mau_pkg::OPND_W]);
    assign w_b32   = 32'(i_s_axis_tdata[mau_pkg::IN_B_LSB +: mau_pkg::OPND_W]);
    assign w_a_sat = (w_a32 >= MODULUS) ? MOD_MAX : RW'(w_a32);
    assign w_b_sat = (w_b32 >= MODULUS) ? MOD_MAX : RW'(w_b32);

    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_add  = (w_sum >= MOD_W) ? (w_sum - MOD_W) : w_sum;
    // Wraps when a < b; adding the modulus brings it back into range.
    assign w_diff = (r_a >= r_b) ? ({1'b0, r_a} - {1'b0, r_b})
                                 : ({1'b0, r_a} + MOD_W - {1'b0, r_b});

    assign w_exp_zero = (r_exp == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mau_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = mau_pkg::ST_EXEC;
                end
            end
            mau_pkg::ST_EXEC: begin
                unique case (r_cmd)
                    mau_pkg::CMD_MUL: n_state = mau_pkg::ST_MUL_WAIT;
                    mau_pkg::CMD_DIV,
                    mau_pkg::CMD_POW,
                    mau_pkg::CMD_INV: n_state = mau_pkg::ST_POW_CHECK;
                    default:          n_state = mau_pkg::ST_OUT;
                endcase
            end
            mau_pkg::ST_POW_CHECK: begin
                priority if (w_exp_zero && (r_cmd == mau_pkg::CMD_DIV)) begin
                    n_state = mau_pkg::ST_MUL_WAIT;
                end else if (w_exp_zero) begin
                    n_state = mau_pkg::ST_OUT;
                end else if (r_exp[0]) begin
                    n_state = mau_pkg::ST_POW_ACC;
                end else begin
                    n_state = mau_pkg::ST_POW_SQ;
                end
            end
            mau_pkg::ST_POW_ACC: begin
                if (mm_done) begin
                    n_state = mau_pkg::ST_POW_SQ;
                end
            end
            mau_pkg::ST_POW_SQ: begin
                if (mm_done) begin
                    n_state = mau_pkg::ST_POW_CHECK;
                end
            end
            mau_pkg::ST_MUL_WAIT: begin
                if (mm_done) begin
                    n_state = mau_pkg::ST_OUT;
                end
            end
            mau_pkg::ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = mau_pkg::ST_IDLE;
                end
            end
            default: n_state = mau_pkg::ST_IDLE;
        endcase
    end

    // Multiplier requests and handshake outputs.
    always_comb begin
        mm_start = 1'b0;
        mm_x     = r_sq;
        mm_y     = r_sq;
        unique case (r_state)
            mau_pkg::ST_EXEC: begin
                if (r_cmd == mau_pkg::CMD_MUL) begin
                    mm_start = 1'b1;
                    mm_x     = r_a;
                    mm_y     = r_b;
                end
            end
            mau_pkg::ST_POW_CHECK: begin
                priority if (w_exp_zero && (r_cmd == mau_pkg::CMD_DIV)) begin
                    // The accumulator now holds the inverse of operand_b.
                    mm_start = 1'b1;
                    mm_x     = r_a;
                    mm_y     = r_acc;
                end else if (!w_exp_zero) begin
                    mm_start = 1'b1;
                    mm_x     = r_exp[0] ? r_acc : r_sq;
                    mm_y     = r_sq;
                end else begin
                end
            end
            mau_pkg::ST_POW_ACC: begin
                mm_start = mm_done;
            end
            default: begin
            end
        endcase
        o_s_axis_tready = (r_state == mau_pkg::ST_IDLE);
        o_m_axis_tvalid = (r_state == mau_pkg::ST_OUT);
    end

    // Datapath next values.
    always_comb begin
        n_cmd = r_cmd;
        n_a   = r_a;
        n_b   = r_b;
        n_eq  = r_eq;
        n_exp = r_exp;
        n_acc = r_acc;
        n_sq  = r_sq;
        n_res = r_res;
        unique case (r_state)
            mau_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd = mau_pkg::t_cmd'(
                        i_s_axis_tdata[mau_pkg::IN_CMD_LSB +: mau_pkg::CMD_W]);
                    n_a   = w_a_sat;
                    n_b   = w_b_sat;
                    n_eq  = (w_a_sat == w_b_sat);
                    n_exp = i_s_axis_tdata[mau_pkg::IN_EXP_LSB +: mau_pkg::EXP_W];
                end
            end
            mau_pkg::ST_EXEC: begin
                unique case (r_cmd)
                    mau_pkg::CMD_ADD: n_res = RW'(w_add);
                    mau_pkg::CMD_SUB: n_res = RW'(w_diff);
                    mau_pkg::CMD_MUL: begin
                    end
                    mau_pkg::CMD_DIV: begin
                        n_acc = ONE;
                        n_sq  = r_b;
                        n_exp = EXP_INV;
                    end
                    mau_pkg::CMD_POW: begin
                        n_acc = ONE;
                        n_sq  = r_a;
                    end
                    mau_pkg::CMD_INV: begin
                        n_acc = ONE;
                        n_sq  = r_a;
                        n_exp = EXP_INV;
                    end
                    default: n_res = '0;
                endcase
            end
            mau_pkg::ST_POW_CHECK: begin
                if (w_exp_zero) begin
                    n_res = r_acc;
                end
            end
            mau_pkg::ST_POW_ACC: begin
                if (mm_done) begin
                    n_acc = mm_z;
                end
            end
            mau_pkg::ST_POW_SQ: begin
                if (mm_done) begin
                    n_sq  = mm_z;
                    n_exp = r_exp >> 1;
                end
            end
            mau_pkg::ST_MUL_WAIT: begin
                if (mm_done) begin
                    n_res = mm_z;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_a   <= n_a;
        r_b   <= n_b;
        r_eq  <= n_eq;
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_res <= n_res;
    end

    assign w_res32 = 32'(r_res);

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[mau_pkg::OUT_RES_LSB +: mau_pkg::RES_W] =
            w_res32[mau_pkg::RES_W-1:0];
        o_m_axis_tdata[mau_pkg::OUT_EQ_BIT] = r_eq;
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Streams directed and random items through the unit and checks each result
// against a behavioural predictor. Sender gaps and receiver stalls change in
// phases, and one long receiver hold-off stalls the input side.
// ----------------------------------------------------------------------------
module tb;

    localparam longint unsigned PRIME      = mau_pkg::DEFAULT_MODULUS;
    localparam longint          PRIME_S    = mau_pkg::DEFAULT_MODULUS;
    localparam int              N_RANDOM   = 2000;
    localparam int              PHASE_LEN  = 200;
    localparam int              HOLD_CYCLES = 3000;
    localparam int              SETTLE_CYCLES = 800;
    localparam longint          CYCLE_LIMIT = 64'd8_000_000;
    localparam int              MAX_REPORTS = 10;

    // Command codes that the unit leaves unused: they return zero.
    localparam logic [mau_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [mau_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [mau_pkg::CMD_W-1:0]  cmd;
        logic [mau_pkg::OPND_W-1:0] opnd_a;
        logic [mau_pkg::OPND_W-1:0] opnd_b;
        logic [mau_pkg::EXP_W-1:0]  expo;
    } t_mod_op;

    typedef struct {
        logic [mau_pkg::RES_W-1:0] residue;
        logic                      equal;
    } t_mod_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mau_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mau_pkg::OUT_TDATA_W-1:0] m_tdata;

    t_mod_op  pending_ops[$];
    t_mod_res expected_residues[$];
    t_mod_op  op_on_bus;

    int     accepted_count = 0;
    int     results_checked = 0;
    int     mismatches = 0;
    int     cmd_seen[8];
    logic   hold_off = 1'b0;
    longint cycle_count = 0;
    int     sender_idle_pct;
    int     receiver_stall_pct;

    modular_arithmetic_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idling phases: none, sender idle, receiver stalling, then both lightly.
    always_comb begin
        case ((accepted_count / PHASE_LEN) % 4)
            0: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct = 83;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 83;
            end
            default: begin
                sender_idle_pct = 13;
                receiver_stall_pct = 13;
            end
        endcase
    end

    function automatic longint unsigned mod_product(input longint unsigned x,
                                                    input longint unsigned y);
        return (x * y) % PRIME;
    endfunction

    function automatic longint unsigned mod_power(input longint unsigned base,
                                                  input logic [mau_pkg::EXP_W-1:0] expo);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq = base;
        for (int i = 0; i < mau_pkg::EXP_W; i++) begin
            if (expo[i])
                acc = mod_product(acc, sq);
            sq = mod_product(sq, sq);
        end
        return acc;
    endfunction

    // Extended Euclid; zero has no inverse and comes out as zero.
    function automatic longint unsigned mod_inverse(input longint unsigned v);
        longint r0;
        longint r1;
        longint c0;
        longint c1;
        longint q;
        longint t;
        r0 = longint'(v);
        r1 = PRIME_S;
        c0 = 1;
        c1 = 0;
        while (r1 != 0) begin
            q = r0 / r1;
            t = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t = c0 - q * c1;
            c0 = c1;
            c1 = t;
        end
        c0 = c0 % PRIME_S;
        if (c0 < 0)
            c0 = c0 + PRIME_S;
        return longint'(c0);
    endfunction

    function automatic t_mod_res predict_residue(input t_mod_op op);
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        t_mod_res res;
        a = (op.opnd_a >= PRIME) ? PRIME - 1 : longint'(op.opnd_a);
        b = (op.opnd_b >= PRIME) ? PRIME - 1 : longint'(op.opnd_b);
        case (op.cmd)
            mau_pkg::CMD_ADD: r = (a + b >= PRIME) ? a + b - PRIME : a + b;
            mau_pkg::CMD_SUB: r = (a >= b) ? a - b : a + PRIME - b;
            mau_pkg::CMD_MUL: r = mod_product(a, b);
            mau_pkg::CMD_DIV: r = mod_product(a, mod_inverse(b));
            mau_pkg::CMD_POW: r = mod_power(a, op.expo);
            mau_pkg::CMD_INV: r = mod_inverse(a);
            default: r = 0;
        endcase
        res.residue = r[mau_pkg::RES_W-1:0];
        res.equal = (a == b);
        return res;
    endfunction

    function automatic logic [mau_pkg::OPND_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return mau_pkg::OPND_W'($urandom);
            1: return mau_pkg::OPND_W'($urandom_range(0, 3));
            2: return mau_pkg::OPND_W'(PRIME - 1 - $urandom_range(0, 2));
            default: return mau_pkg::OPND_W'($urandom_range(0, int'(PRIME - 1)));
        endcase
    endfunction

    // Mostly short exponents keep power items quick; a few use all the bits.
    function automatic logic [mau_pkg::EXP_W-1:0] random_exponent();
        logic [63:0] raw;
        int          bits;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            return raw[mau_pkg::EXP_W-1:0];
        bits = $urandom_range(0, 16);
        return mau_pkg::EXP_W'(raw & ((64'd1 << bits) - 1));
    endfunction

    task automatic queue_op(input logic [mau_pkg::CMD_W-1:0] cmd,
                            input longint unsigned a, input longint unsigned b,
                            input logic [mau_pkg::EXP_W-1:0] expo);
        t_mod_op op;
        op.cmd = cmd;
        op.opnd_a = mau_pkg::OPND_W'(a);
        op.opnd_b = mau_pkg::OPND_W'(b);
        op.expo = expo;
        pending_ops = {pending_ops, op};
    endtask

    // Driver: offers the next pending item, or idles, whenever the bus is free.
    always @(posedge i_clk) begin : drive_items
        t_mod_op next_op;
        logic [mau_pkg::IN_TDATA_W-1:0] next_data;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_residues = {expected_residues, predict_residue(op_on_bus)};
                accepted_count <= accepted_count + 1;
                cmd_seen[op_on_bus.cmd] <= cmd_seen[op_on_bus.cmd] + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_op = pending_ops.pop_front();
                    next_data = '0;
                    next_data[mau_pkg::IN_CMD_LSB +: mau_pkg::CMD_W] = next_op.cmd;
                    next_data[mau_pkg::IN_A_LSB +: mau_pkg::OPND_W] = next_op.opnd_a;
                    next_data[mau_pkg::IN_B_LSB +: mau_pkg::OPND_W] = next_op.opnd_b;
                    next_data[mau_pkg::IN_EXP_LSB +: mau_pkg::EXP_W] = next_op.expo;
                    op_on_bus <= next_op;
                    s_tdata <= next_data;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results, stalling at random, and checks them in order.
    always @(posedge i_clk) begin : check_results
        t_mod_res want;
        logic [mau_pkg::RES_W-1:0] got_res;
        logic got_eq;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_res = m_tdata[mau_pkg::OUT_RES_LSB +: mau_pkg::RES_W];
                got_eq = m_tdata[mau_pkg::OUT_EQ_BIT];
                if (expected_residues.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: residue %0d, equal %0b",
                                 got_res, got_eq);
                end else begin
                    want = expected_residues.pop_front();
                    results_checked++;
                    if (got_res !== want.residue || got_eq !== want.equal) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"Mismatch on result %0d: expected residue %0d ",
                                      "equal %0b, got residue %0d equal %0b"},
                                     results_checked, want.residue, want.equal,
                                     got_res, got_eq);
                    end
                end
            end
            m_tready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modular_arithmetic_unit test failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial begin
        wait (accepted_count >= 60);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : main
        t_mod_op op;
        for (int i = 0; i < 8; i++)
            cmd_seen[i] = 0;

        // Directed items: wrap-around, saturation, zero inverse, zero exponent.
        queue_op(mau_pkg::CMD_ADD, 0, 0, '0);
        queue_op(mau_pkg::CMD_ADD, PRIME - 1, PRIME - 1, '0);
        queue_op(mau_pkg::CMD_ADD, PRIME - 1, 1, '0);
        queue_op(mau_pkg::CMD_ADD, 30'h3FFF_FFFF, 5, '1);
        queue_op(mau_pkg::CMD_SUB, 0, 1, '0);
        queue_op(mau_pkg::CMD_SUB, 12345, 12345, '0);
        queue_op(mau_pkg::CMD_SUB, PRIME, PRIME - 1, '0);
        queue_op(mau_pkg::CMD_MUL, PRIME - 1, PRIME - 1, '0);
        queue_op(mau_pkg::CMD_MUL, 0, 30'h3FFF_FFFF, '0);
        queue_op(mau_pkg::CMD_DIV, 777, 0, '0);
        queue_op(mau_pkg::CMD_DIV, 987654321, 1, '0);
        queue_op(mau_pkg::CMD_DIV, 424242, 424242, '0);
        queue_op(mau_pkg::CMD_DIV, 30'h3FFF_FFFF, PRIME - 1, '0);
        queue_op(mau_pkg::CMD_POW, 0, 0, '0);
        queue_op(mau_pkg::CMD_POW, 123456789, 0, '0);
        queue_op(mau_pkg::CMD_POW, 2, '1, '0);
        queue_op(mau_pkg::CMD_POW, PRIME - 1, 2, '1);
        queue_op(mau_pkg::CMD_POW, 0, 1, 63'd5);
        queue_op(mau_pkg::CMD_INV, 0, 0, '0);
        queue_op(mau_pkg::CMD_INV, 1, 0, '0);
        queue_op(mau_pkg::CMD_INV, PRIME - 1, 3, '0);
        queue_op(mau_pkg::CMD_INV, 30'h3FFF_FFFF, 30'h3FFF_FFFF, '0);
        queue_op(CMD_SPARE_6, 55, 55, '1);
        queue_op(CMD_SPARE_7, 30'h3FFF_FFFF, 0, '1);

        for (int n = 0; n < N_RANDOM; n++) begin
            op.cmd = mau_pkg::CMD_W'($urandom_range(0, 7));
            op.opnd_a = random_operand();
            op.opnd_b = ($urandom_range(0, 7) == 0) ? op.opnd_a : random_operand();
            op.expo = random_exponent();
            pending_ops = {pending_ops, op};
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_residues.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_residues.size() != 0)
            mismatches += expected_residues.size();

        $display({"Checked %0d results from %0d items: add %0d, sub %0d, mul %0d, ",
                  "div %0d, pow %0d, inv %0d, unused %0d."},
                 results_checked, accepted_count, cmd_seen[mau_pkg::CMD_ADD],
                 cmd_seen[mau_pkg::CMD_SUB], cmd_seen[mau_pkg::CMD_MUL],
                 cmd_seen[mau_pkg::CMD_DIV], cmd_seen[mau_pkg::CMD_POW],
                 cmd_seen[mau_pkg::CMD_INV],
                 cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7]);
        $display({"Sender gaps and receiver stalls ran in phases, with one hold-off ",
                  "of %0d cycles; %0d failures."},
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("modular_arithmetic_unit test passed");
        end else begin
            $display("modular_arithmetic_unit test failed");
        end
        $finish;
    end

endmodule
